>>> rtl/fcsl_pkg.sv
// ----------------------------------------------------------------------------
// fcsl_pkg: shared types and constants of the FAT16 chain sector locator
// Item types, operation and status codes, table marks, register addresses and sizes.
// ----------------------------------------------------------------------------
package fcsl_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int DIV_STEPS         = 32;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_LOCATE    = 2'd1;
    localparam logic [1:0] OP_FIND_FREE = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EOC    = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;
    localparam logic [1:0] STAT_NOFREE = 2'd3;

    localparam logic [15:0] END_MARK           = 16'hFFFF;
    localparam logic [15:0] FREE_MARK          = 16'h0000;
    localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;

    localparam logic [2:0] REG_SPC_ADDR = 3'd0;
    localparam logic [2:0] REG_DSS_ADDR = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cluster;
        logic [31:0] file_sector;
        logic [15:0] link_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] sector;
        logic [15:0] found_cluster;
        logic [1:0]  status;
    } out_item_t;

endpackage

>>> rtl/fat16_chain_sector_locator_top.sv
// ----------------------------------------------------------------------------
// fat16_chain_sector_locator_top: FAT16 cluster chain walker and sector locator
// Holds the link table, walks chains, finds free clusters, maps file sectors.
// ----------------------------------------------------------------------------
// After reset the block clears its link table, one entry per cycle; in_ready
// stays low during that pass while the APB registers are writable at once.
// It then takes one item at a time and returns exactly one result item for
// it. A table write, an unused op code and a scan starting beyond the table
// finish in the accept cycle. A find-free item primes the read of its start
// entry, then scans, reading one RAM entry per cycle. A locate item runs the
// bit-serial division of file_sector by sectors_per_cluster, then follows
// chain links with one RAM read per cycle and checks the cluster reached;
// when a sector is found, the multiply and the final add follow. in_ready
// is high only when the block is idle and its output register is empty or
// being emptied in the same cycle.
// ----------------------------------------------------------------------------
module fat16_chain_sector_locator_top #(
    parameter int TABLE_ENTRIES = fcsl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // item input
    input  logic                in_valid,
    output logic                in_ready,
    input  fcsl_pkg::in_item_t  in_data,
    // result output
    output logic                out_valid,
    input  logic                out_ready,
    output fcsl_pkg::out_item_t out_data,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int TAKEN_W = IDX_W + 1;
    localparam int STEP_W  = $clog2(fcsl_pkg::DIV_STEPS);

    localparam logic [16:0]        N_VAL      = 17'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [TAKEN_W-1:0] TAKEN_MAX  = TAKEN_W'(TABLE_ENTRIES);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(fcsl_pkg::DIV_STEPS - 1);

    // sequencer state codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PRIME = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_ADD   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [15:0]         cur_reg, cur_next;
    logic [TAKEN_W-1:0]  taken_reg, taken_next;
    logic [31:0]         quo_reg, quo_next;      // dividend, then link count
    logic [7:0]          rem_reg, rem_next;      // sector within cluster
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [23:0]         prod_reg, prod_next;
    logic                out_valid_reg, out_valid_next;
    fcsl_pkg::out_item_t out_data_reg, out_data_next;
    logic [7:0]          spc_reg, spc_next;
    logic [31:0]         dss_reg, dss_next;

    // table RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [15:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [15:0]      ram_rdata;

    fcsl_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic        accept;
    logic        cfg_write;
    logic [7:0]  spc_eff;
    logic [8:0]  div_trial;
    logic        div_ge;
    logic        cur_beyond;
    logic        in_beyond;
    logic [15:0] cur_inc;
    logic [15:0] clu_off;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? dss_reg : {24'd0, spc_reg};

    // a cluster size of zero behaves as one
    assign spc_eff = (spc_reg == 8'd0) ? 8'd1 : spc_reg;

    // restoring divider step: one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[31]};
    assign div_ge    = div_trial >= {1'b0, spc_eff};

    assign cur_beyond = {1'b0, cur_reg} >= N_VAL;
    assign in_beyond  = {1'b0, in_data.cluster} >= N_VAL;
    assign cur_inc    = cur_reg + 16'd1;
    assign clu_off    = cur_reg - fcsl_pkg::FIRST_DATA_CLUSTER;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_comb
    begin
        spc_next = spc_reg;
        dss_next = dss_reg;
        if (cfg_write)
        begin
            if (paddr[2])
            begin
                dss_next = pwdata;
            end
            else
            begin
                spc_next = pwdata[7:0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        taken_next     = taken_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = in_data.cluster[IDX_W-1:0];
        ram_wdata      = in_data.link_value;
        ram_raddr      = cur_reg[IDX_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep zeros through the table
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = fcsl_pkg::FREE_MARK;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.op)
                        fcsl_pkg::OP_WRITE:
                        begin
                            ram_we         = !in_beyond;
                            out_valid_next = 1'b1;
                            out_data_next  = '{sector: 32'd0,
                                               found_cluster: in_data.cluster,
                                               status: in_beyond ? fcsl_pkg::STAT_RANGE
                                                                 : fcsl_pkg::STAT_OK};
                        end
                        fcsl_pkg::OP_LOCATE:
                        begin
                            cur_next   = in_data.cluster;
                            quo_next   = in_data.file_sector;
                            rem_next   = 8'd0;
                            step_next  = '0;
                            taken_next = '0;
                            state_next = S_DIV;
                        end
                        fcsl_pkg::OP_FIND_FREE:
                        begin
                            if (in_beyond)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '{sector: 32'd0,
                                                   found_cluster: in_data.cluster,
                                                   status: fcsl_pkg::STAT_RANGE};
                            end
                            else
                            begin
                                cur_next   = in_data.cluster;
                                state_next = S_PRIME;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{sector: 32'd0,
                                               found_cluster: 16'd0,
                                               status: fcsl_pkg::STAT_RANGE};
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                // the start entry is read meanwhile, so the walk sees it at once
                quo_next  = {quo_reg[30:0], div_ge};
                rem_next  = div_ge ? 8'(div_trial - {1'b0, spc_eff}) : div_trial[7:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_WALK;
                end
            end
            S_PRIME:
            begin
                state_next = S_SCAN;
            end
            S_WALK:
            begin
                if (cur_reg == fcsl_pkg::END_MARK)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{sector: 32'd0, found_cluster: cur_reg,
                                       status: fcsl_pkg::STAT_EOC};
                    state_next     = S_IDLE;
                end
                else if (cur_beyond)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{sector: 32'd0, found_cluster: cur_reg,
                                       status: fcsl_pkg::STAT_RANGE};
                    state_next     = S_IDLE;
                end
                else if (32'(taken_reg) == quo_reg)
                begin
                    if (cur_reg < fcsl_pkg::FIRST_DATA_CLUSTER)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{sector: 32'd0, found_cluster: cur_reg,
                                           status: fcsl_pkg::STAT_RANGE};
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else if (taken_reg == TAKEN_MAX)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{sector: 32'd0, found_cluster: cur_reg,
                                       status: fcsl_pkg::STAT_RANGE};
                    state_next     = S_IDLE;
                end
                else
                begin
                    // follow the link and fetch the next one right away
                    cur_next   = ram_rdata;
                    taken_next = taken_reg + TAKEN_W'(1);
                    ram_raddr  = ram_rdata[IDX_W-1:0];
                end
            end
            S_SCAN:
            begin
                if (ram_rdata == fcsl_pkg::FREE_MARK)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{sector: 32'd0, found_cluster: cur_reg,
                                       status: fcsl_pkg::STAT_OK};
                    state_next     = S_IDLE;
                end
                else if (cur_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{sector: 32'd0, found_cluster: 16'd0,
                                       status: fcsl_pkg::STAT_NOFREE};
                    state_next     = S_IDLE;
                end
                else
                begin
                    cur_next  = cur_inc;
                    ram_raddr = cur_inc[IDX_W-1:0];
                end
            end
            S_MUL:
            begin
                prod_next  = {8'd0, clu_off} * {16'd0, spc_eff};
                state_next = S_ADD;
            end
            S_ADD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{sector: {8'd0, prod_reg} + dss_reg + {24'd0, rem_reg},
                                   found_cluster: cur_reg,
                                   status: fcsl_pkg::STAT_OK};
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            spc_reg       <= 8'd1;
            dss_reg       <= 32'd0;
            taken_reg     <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            spc_reg       <= spc_next;
            dss_reg       <= dss_next;
            taken_reg     <= taken_next;
            step_reg      <= step_next;
        end
    end

    // payload registers hold no reset
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    // the table changes only in the clearing pass or when an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || accept))
        else $error("table written outside clear pass or item accept");

    // the walk never goes beyond one pass over the table
    assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= TAKEN_MAX)
        else $error("link count exceeded table size");

    // while an item is in work the output slot is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_CLEAR) |-> !out_valid_reg)
        else $error("result pending while an item is in work");

    // a locate that reaches the final add finishes into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("locate result not delivered after final add");

endmodule

>>> rtl/fcsl_ram.sv
// ----------------------------------------------------------------------------
// fcsl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fcsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = fcsl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> dv/fcsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsl_checker: result scoreboard for the FAT16 chain sector locator
// Tracks APB register writes, mirrors the link table, predicts one reply per
// accepted item and compares replies field by field, in order.
// ----------------------------------------------------------------------------
module fcsl_checker #(
    parameter int TABLE_ENTRIES = fcsl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  fcsl_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  fcsl_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  pending,
    output int                  results_checked
);
    import fcsl_pkg::*;

    logic [15:0] link_mem [0:TABLE_ENTRIES-1];
    logic [7:0]  spc_reg;
    logic [31:0] dss_reg;
    out_item_t   fat_replies_q [$];
    out_item_t   want;

    task automatic report_bad(input string msg);
        begin
            if (fail_count < 10)
                $display("%0t ns: %s", $time, msg);
            fail_count++;
        end
    endtask

    // Apply one item to the mirrored table and return the reply it must cause.
    function automatic out_item_t walk_fat(input in_item_t it);
        out_item_t   r;
        logic [31:0] spc_eff;
        logic [31:0] links;
        logic [31:0] sec_in_clu;
        logic [31:0] cur;
        logic [31:0] taken;
        int          idx;
        bit          done;
        begin
            r = '0;
            case (it.op)
                OP_WRITE:
                begin
                    r.found_cluster = it.cluster;
                    if (it.cluster < TABLE_ENTRIES)
                    begin
                        link_mem[it.cluster] = it.link_value;
                        r.status = STAT_OK;
                    end
                    else
                    begin
                        r.status = STAT_RANGE;
                    end
                end
                OP_LOCATE:
                begin
                    spc_eff    = (spc_reg == 8'd0) ? 32'd1 : {24'd0, spc_reg};
                    links      = it.file_sector / spc_eff;
                    sec_in_clu = it.file_sector % spc_eff;
                    cur        = {16'd0, it.cluster};
                    taken      = 32'd0;
                    done       = 1'b0;
                    while (!done)
                    begin
                        done = 1'b1;
                        if (cur == {16'd0, END_MARK})
                        begin
                            r.found_cluster = END_MARK;
                            r.status        = STAT_EOC;
                        end
                        else if (cur >= TABLE_ENTRIES)
                        begin
                            r.found_cluster = cur[15:0];
                            r.status        = STAT_RANGE;
                        end
                        else if (taken == links)
                        begin
                            r.found_cluster = cur[15:0];
                            if (cur < {16'd0, FIRST_DATA_CLUSTER})
                            begin
                                r.status = STAT_RANGE;
                            end
                            else
                            begin
                                r.sector = (cur - {16'd0, FIRST_DATA_CLUSTER}) * spc_eff
                                           + dss_reg + sec_in_clu;
                                r.status = STAT_OK;
                            end
                        end
                        else if (taken >= TABLE_ENTRIES)
                        begin
                            r.found_cluster = cur[15:0];
                            r.status        = STAT_RANGE;
                        end
                        else
                        begin
                            cur   = {16'd0, link_mem[cur]};
                            taken = taken + 32'd1;
                            done  = 1'b0;
                        end
                    end
                end
                OP_FIND_FREE:
                begin
                    if (it.cluster >= TABLE_ENTRIES)
                    begin
                        r.found_cluster = it.cluster;
                        r.status        = STAT_RANGE;
                    end
                    else
                    begin
                        r.status = STAT_NOFREE;
                        for (idx = int'(it.cluster); idx < TABLE_ENTRIES; idx++)
                        begin
                            if (link_mem[idx] == FREE_MARK && r.status == STAT_NOFREE)
                            begin
                                r.found_cluster = idx[15:0];
                                r.status        = STAT_OK;
                            end
                        end
                    end
                end
                default: r.status = STAT_RANGE;
            endcase
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                link_mem[i] = FREE_MARK;
            spc_reg = 8'd1;
            dss_reg = 32'd0;
            fat_replies_q.delete();
            pending         = 0;
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            // register port
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == REG_SPC_ADDR)
                        spc_reg = pwdata[7:0];
                    else if (paddr == REG_DSS_ADDR)
                        dss_reg = pwdata;
                end
                else if (paddr == REG_SPC_ADDR && prdata !== {24'd0, spc_reg})
                begin
                    report_bad($sformatf("cluster size readback: exp %08h got %08h",
                                         {24'd0, spc_reg}, prdata));
                end
                else if (paddr == REG_DSS_ADDR && prdata !== dss_reg)
                begin
                    report_bad($sformatf("data start readback: exp %08h got %08h",
                                         dss_reg, prdata));
                end
            end
            // replies first: a reply leaving now belongs to an older item
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (fat_replies_q.size() == 0)
                begin
                    report_bad($sformatf("unexpected reply sector=%08h cluster=%04h status=%0d",
                                         out_data.sector, out_data.found_cluster,
                                         out_data.status));
                end
                else
                begin
                    want = fat_replies_q.pop_front();
                    if (out_data.sector !== want.sector ||
                        out_data.found_cluster !== want.found_cluster ||
                        out_data.status !== want.status)
                        report_bad($sformatf({"reply mismatch: exp sector=%08h cluster=%04h ",
                                              "status=%0d, got sector=%08h cluster=%04h ",
                                              "status=%0d"},
                                             want.sector, want.found_cluster, want.status,
                                             out_data.sector, out_data.found_cluster,
                                             out_data.status));
                end
            end
            if (in_valid && in_ready)
                fat_replies_q.push_back(walk_fat(in_data));
            pending = fat_replies_q.size();
        end
    end

endmodule

>>> dv/tb_fat16_chain_sector_locator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat16_chain_sector_locator_top: regression for the FAT16 sector locator
// Drives directed corner items, then random chain builds, locates, scans and
// noise under several volume settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_fat16_chain_sector_locator_top;
    import fcsl_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    // op code the block must reject
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 64;
    // watchdog limit, far above the real need even with long walks
    localparam longint LIMIT_NS   = 64'd150_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent     = 0;
    int settings_used  = 0;
    int spc_now        = 1;
    int sender_calm    = 0;
    int receiver_calm  = 0;

    always #10 clk = ~clk;

    fat16_chain_sector_locator_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fcsl_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_checked(results_checked)
    );

    // Draw the idle cycles before the next item. Now and then start a calm
    // stretch in which no idling happens at all.
    function automatic int draw_gap(inout int calm);
        begin
            if (calm > 0)
            begin
                calm--;
                return 0;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                calm = $urandom_range(8, 40);
                return 0;
            end
            return $urandom_range(0, 16);
        end
    endfunction

    function automatic in_item_t mk_item(input logic [1:0] op, input logic [15:0] clu,
                                         input logic [31:0] fsec, input logic [15:0] link);
        in_item_t it;
        begin
            it.op          = op;
            it.cluster     = clu;
            it.file_sector = fsec;
            it.link_value  = link;
            return it;
        end
    endfunction

    // Offer one item after a random gap and hold it until accepted.
    // Enter and leave at a falling edge.
    task automatic send_item(input in_item_t it);
        int gap;
        begin
            gap = draw_gap(sender_calm);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= it;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            @(negedge clk);
            items_sent++;
        end
    endtask

    // APB access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= addr;
            pwdata  <= data;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Program both volume registers and read them back; the checker compares.
    task automatic set_volume(input logic [7:0] spc, input logic [31:0] dss);
        begin
            apb_access(1'b1, REG_SPC_ADDR, {24'd0, spc});
            apb_access(1'b1, REG_DSS_ADDR, dss);
            apb_access(1'b0, REG_SPC_ADDR, 32'd0);
            apb_access(1'b0, REG_DSS_ADDR, 32'd0);
            spc_now = int'(spc);
            settings_used++;
        end
    endtask

    // Drop valid and wait until every reply is back, so the block is idle.
    task automatic drain_replies();
        begin
            in_valid <= 1'b0;
            while (pending != 0) @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    // Random traffic. Most of it builds a short chain and then locates
    // sectors along it (some just past its end); the rest is scans, raw
    // writes anywhere in the 16-bit range, full-width locates and bad ops.
    task automatic run_random(input int count);
        int          n;
        int          kind;
        int          len;
        int          reps;
        int          spc_eff;
        logic [15:0] chain [0:7];
        logic [15:0] clu;
        begin
            n = 0;
            while (n < count)
            begin
                kind    = $urandom_range(0, 99);
                spc_eff = (spc_now == 0) ? 1 : spc_now;
                if (kind < 60)
                begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        chain[i] = 16'($urandom_range(FIRST_DATA_CLUSTER, TABLE_ENTRIES - 1));
                    for (int i = 0; i < len; i++)
                    begin
                        send_item(mk_item(OP_WRITE, chain[i], $urandom,
                                          (i == len - 1) ? END_MARK : chain[i + 1]));
                        n++;
                    end
                    reps = $urandom_range(1, 4);
                    for (int i = 0; i < reps; i++)
                    begin
                        send_item(mk_item(OP_LOCATE, chain[0],
                                          $urandom_range(0, (len + 1) * spc_eff - 1),
                                          16'($urandom)));
                        n++;
                    end
                end
                else if (kind < 75)
                begin
                    clu = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, TABLE_ENTRIES - 1));
                    send_item(mk_item(OP_FIND_FREE, clu, $urandom, 16'($urandom)));
                    n++;
                end
                else if (kind < 90)
                begin
                    clu = $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'($urandom_range(0, TABLE_ENTRIES - 1));
                    send_item(mk_item(OP_WRITE, clu, $urandom, 16'($urandom)));
                    n++;
                end
                else if (kind < 95)
                begin
                    // full-width offset: mostly ends on a loop or a bad link
                    clu = $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'($urandom_range(0, TABLE_ENTRIES - 1));
                    send_item(mk_item(OP_LOCATE, clu, $urandom, 16'($urandom)));
                    n++;
                end
                else
                begin
                    send_item(mk_item($urandom_range(0, 1) ? OP_UNUSED : 2'($urandom),
                                      16'($urandom), $urandom, 16'($urandom)));
                    n++;
                end
            end
        end
    endtask

    // Receiver: random stall before each reply, plus two long hold-offs so
    // the sender keeps offering while the block backs up and drops in_ready.
    initial
    begin
        int gap;
        int taken_cnt;
        taken_cnt = 0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (taken_cnt == 120 || taken_cnt == 380)
                gap = LONG_HOLD;
            else
                gap = draw_gap(receiver_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken_cnt++;
            @(negedge clk);
        end
    end

    // Main sequence.
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers are writable during the table clearing pass; read the
        // reset values first.
        apb_access(1'b0, REG_SPC_ADDR, 32'd0);
        apb_access(1'b0, REG_DSS_ADDR, 32'd0);

        // Directed corners under the reset volume setting.
        send_item(mk_item(OP_FIND_FREE, 16'd0, 32'd0, 16'd0));        // empty table
        send_item(mk_item(OP_WRITE, 16'd2, 32'd0, 16'd3));
        send_item(mk_item(OP_WRITE, 16'd3, 32'd0, END_MARK));
        send_item(mk_item(OP_LOCATE, 16'd2, 32'd0, 16'd0));          // start cluster
        send_item(mk_item(OP_LOCATE, 16'd2, 32'd1, 16'd0));          // one link
        send_item(mk_item(OP_LOCATE, 16'd2, 32'd2, 16'd0));          // hits chain end
        send_item(mk_item(OP_LOCATE, END_MARK, 32'd0, 16'd0));       // start is end mark
        send_item(mk_item(OP_LOCATE, 16'd5000, 32'd0, 16'd0));       // start beyond table
        send_item(mk_item(OP_LOCATE, 16'd0, 32'd0, 16'd0));          // reserved target
        send_item(mk_item(OP_LOCATE, 16'd1, 32'd0, 16'd0));          // reserved target
        send_item(mk_item(OP_WRITE, 16'(TABLE_ENTRIES - 1), 32'd0, END_MARK));
        send_item(mk_item(OP_WRITE, 16'(TABLE_ENTRIES), 32'd0, 16'd5)); // index beyond table
        send_item(mk_item(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 16'd0));
        send_item(mk_item(OP_WRITE, 16'd10, 32'd0, 16'd10));         // self loop
        send_item(mk_item(OP_LOCATE, 16'd10, 32'hFFFF_FFFF, 16'd0)); // long walk
        send_item(mk_item(OP_LOCATE, 16'd10, 32'(TABLE_ENTRIES), 16'd0)); // walk at limit
        send_item(mk_item(OP_LOCATE, 16'd10, 32'(TABLE_ENTRIES + 1), 16'd0));
        send_item(mk_item(OP_WRITE, 16'd20, 32'd0, 16'd9000));       // bad link
        send_item(mk_item(OP_LOCATE, 16'd20, 32'd1, 16'd0));
        send_item(mk_item(OP_FIND_FREE, 16'(TABLE_ENTRIES), 32'd0, 16'd0));
        send_item(mk_item(OP_FIND_FREE, 16'hFFFF, 32'd0, 16'd0));
        send_item(mk_item(OP_WRITE, 16'(TABLE_ENTRIES - 2), 32'd0, 16'd1));
        send_item(mk_item(OP_FIND_FREE, 16'(TABLE_ENTRIES - 2), 32'd0, 16'd0)); // none free
        send_item(mk_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(mk_item(OP_FIND_FREE, 16'd2, 32'd0, 16'd0));
        drain_replies();

        // Random phases, each under its own volume setting.
        set_volume(8'd128, 32'hFFFF_FFFF);
        run_random(ITEMS_PER_PHASE);
        drain_replies();

        set_volume(8'd0, $urandom);            // zero cluster size acts as one
        run_random(ITEMS_PER_PHASE);
        drain_replies();

        set_volume(8'd255, 32'd0);
        run_random(ITEMS_PER_PHASE);
        drain_replies();

        set_volume(8'($urandom_range(1, 128)), $urandom);
        run_random(ITEMS_PER_PHASE);
        drain_replies();

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Drove %0d items and compared %0d replies (writes, locates, scans, bad ops).",
                 items_sent, results_checked);
        $display("Used %0d volume settings besides reset, cluster sizes 0, 128, 255 and random.",
                 settings_used);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
